### hw/rtl/brb_pkg.sv
// Shared types, constants and codes for the byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

    // Store geometry; DEPTH is a power of two so pointers wrap naturally
    localparam int DEPTH  = 64;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CAP    = DEPTH - 1;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int FILL_W = 6;

    // Operation codes; code 3 carries no operation
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PUSH = 2'd0;
    localparam kind_t KIND_GET  = 2'd1;
    localparam kind_t KIND_SKIP = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOT_YET = 2'd1,
        ST_NEVER   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  push_byte;
        logic [LEN_W-1:0]   length;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        status_t            status;
        logic               last;
        logic [FILL_W-1:0]  fill_level;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_STREAM
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic item_load;
        logic single_load;
        logic push_commit;
        logic skip_commit;
        logic read_issue;
        logic byte_load;
    } brb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_push;
        logic is_get;
        logic is_skip;
        logic full;
        logic short_len;
        logic zero_len;
        logic out_free;
        logic last_byte;
    } brb_stat_t;

endpackage

`default_nettype wire

### hw/rtl/byte_ring_buffer_exact_get.sv
// Top level of the byte ring buffer with exact-length get and skip.
//
// Request channel (req_valid/req_ready/req): one transfer per operation:
// push a byte, get length bytes, or skip length bytes. Kind 3 is dropped.
// Response channel (rsp_valid/rsp_ready/rsp): one transfer per result. A
// successful get of N bytes gives N transfers, last set on the final one;
// every other operation gives one transfer. Each result carries the fill
// level after it.
// The store holds up to DEPTH-1 = 63 bytes in a single-port-per-side RAM.
// A request is taken only while the controller is idle. A push, skip,
// zero-length request or failed check loads its result once the output
// register is free and opens the request side in that same cycle. A get
// checks the item, reads its first byte from the RAM, then streams one byte
// per cycle while rsp_ready stays high. A dropped kind yields no result.
// A request may be taken while the previous result still waits in the
// output register; it is held and resolved once that register frees.
// When the receiver stalls, the result register holds and streaming pauses.
// Reset clears both pointers (empty buffer) and the response valid; the RAM
// content is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_exact_get
    import brb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    brb_cmd_t  cmd;
    brb_stat_t stat;

    brb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    brb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef SYNTH
    // No request is taken while a get is still streaming
    a_no_req_mid_stream: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !(rsp_valid && rsp.byte_valid && !rsp.last))
        else $error("request side open during a get stream");

    // A streamed byte always carries ok status
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.byte_valid) |-> (rsp.status == ST_OK))
        else $error("streamed byte with non-ok status");

    // A result without a byte is a single, final result with zero data
    a_single_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.byte_valid) |-> (rsp.last && rsp.out_byte == '0))
        else $error("malformed single result");
`endif

endmodule

`default_nettype wire

### hw/rtl/brb_datapath.sv
// Datapath: byte store, pointers, item register and result register.
`timescale 1ns / 1ps
`default_nettype none

module brb_datapath
    import brb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_t      req,
    input  wire brb_cmd_t  cmd,
    output brb_stat_t      stat,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_t           rsp
);

    logic [BYTE_W-1:0] mem [DEPTH];

    req_t              item_reg;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  left_reg, left_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic [PTR_W-1:0]  fill;
    logic [PTR_W-1:0]  len_lo;
    logic              never;
    rsp_t              single;

    // Derive fill and the checks on the held item
    always_comb
    begin
        fill           = wp_reg - rp_reg;
        len_lo         = item_reg.length[PTR_W-1:0];
        never          = item_reg.length > LEN_W'(CAP);
        stat.is_push   = item_reg.kind == KIND_PUSH;
        stat.is_get    = item_reg.kind == KIND_GET;
        stat.is_skip   = item_reg.kind == KIND_SKIP;
        stat.full      = fill == PTR_W'(CAP);
        stat.short_len = LEN_W'(fill) < item_reg.length;
        stat.zero_len  = item_reg.length == '0;
        stat.out_free  = !rsp_valid_reg || rsp_ready;
        stat.last_byte = left_reg == PTR_W'(1);
    end

    // Build the one result of a push, a skip, a zero length or a failed check
    always_comb
    begin
        single            = '0;
        single.last       = 1'b1;
        single.status     = ST_OK;
        single.fill_level = FILL_W'(fill);
        if (stat.is_push)
        begin
            if (stat.full)
                single.status = ST_FULL;
            else
                single.fill_level = FILL_W'(fill + PTR_W'(1));
        end
        else if (stat.short_len)
            single.status = never ? ST_NEVER : ST_NOT_YET;
        else if (!stat.zero_len)
            single.fill_level = FILL_W'(fill - len_lo);
    end

    // Advance pointers, byte count and the result register
    always_comb
    begin
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        left_next      = left_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
            rsp_valid_next = 1'b0;
        if (cmd.item_load)
            left_next = req.length[PTR_W-1:0];
        if (cmd.push_commit)
            wp_next = wp_reg + PTR_W'(1);
        if (cmd.skip_commit)
            rp_next = rp_reg + len_lo;
        if (cmd.read_issue)
            rp_next = rp_reg + PTR_W'(1);
        if (cmd.single_load)
        begin
            rsp_next       = single;
            rsp_valid_next = 1'b1;
        end
        if (cmd.byte_load)
        begin
            rsp_next.out_byte   = rd_data_reg;
            rsp_next.byte_valid = 1'b1;
            rsp_next.status     = ST_OK;
            rsp_next.last       = stat.last_byte;
            rsp_next.fill_level = FILL_W'(fill);
            left_next           = left_reg - PTR_W'(1);
            rsp_valid_next      = 1'b1;
        end
    end

    // Hold control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        rsp_reg  <= rsp_next;
        if (cmd.item_load)
            item_reg <= req;
    end

    // Write and read the byte store
    always_ff @(posedge clk)
    begin
        if (cmd.push_commit)
            mem[wp_reg] <= item_reg.push_byte;
        if (cmd.read_issue)
            rd_data_reg <= mem[rp_reg];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

### hw/rtl/brb_ctrl.sv
// Controller: sequences item capture, single results and byte streaming.
`timescale 1ns / 1ps
`default_nettype none

module brb_ctrl
    import brb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire brb_stat_t  stat,
    output brb_cmd_t        cmd
);

    state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Decide next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!(stat.is_push || stat.is_get || stat.is_skip))
                    state_next = S_IDLE;
                else if (stat.is_get && !stat.short_len && !stat.zero_len)
                begin
                    // Prefetch the first byte of the get
                    cmd.read_issue = 1'b1;
                    state_next     = S_STREAM;
                end
                else if (stat.out_free)
                begin
                    cmd.single_load = 1'b1;
                    cmd.push_commit = stat.is_push && !stat.full;
                    cmd.skip_commit = stat.is_skip && !stat.short_len && !stat.zero_len;
                    state_next      = S_IDLE;
                end
            end
            S_STREAM:
            begin
                if (stat.out_free)
                begin
                    cmd.byte_load = 1'b1;
                    if (stat.last_byte)
                        state_next = S_IDLE;
                    else
                        cmd.read_issue = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### sim/byte_ring_buffer_exact_get_tb.sv
// Self-checking testbench for the byte ring buffer with exact-length get and skip.
`timescale 1ns / 1ps

module byte_ring_buffer_exact_get_tb
    import brb_pkg::*;
();

    // Kind code that the block drops without a result
    localparam kind_t KIND_NONE    = 2'd3;
    localparam int    RANDOM_ITEMS = 138;
    localparam int    STALL_CYCLES = 300;
    localparam int    DRAIN_CYCLES = 16;
    localparam int    REPORT_MAX   = 10;

    // One line of the directed table; want is used only when typed is set
    typedef struct {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   len;
        int                 reps;
        bit                 typed;
        rsp_t               want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Shadow copy of the ring and the results still owed by the block
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    logic [PTR_W-1:0]  ring_rd = '0;
    logic [PTR_W-1:0]  ring_wr = '0;
    rsp_t              due_results[$];

    int errors        = 0;
    int send_idle_pct = 31;
    int recv_idle_pct = 51;
    bit stall_rsp     = 1'b0;
    bit filling       = 1'b1;

    byte_ring_buffer_exact_get dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        #(12_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic rsp_t make_rsp(logic [BYTE_W-1:0] data, logic valid, status_t st,
                                      logic fin, logic [FILL_W-1:0] fill);
        rsp_t r;
        r.out_byte   = data;
        r.byte_valid = valid;
        r.status     = st;
        r.last       = fin;
        r.fill_level = fill;
        return r;
    endfunction

    // Single result that carries no byte
    function automatic rsp_t done_rsp(status_t st, logic [FILL_W-1:0] fill);
        return make_rsp('0, 1'b0, st, 1'b1, fill);
    endfunction

    function automatic dir_row_t row(kind_t kind, logic [BYTE_W-1:0] data,
                                     logic [LEN_W-1:0] len, int reps, bit typed, rsp_t want);
        dir_row_t d;
        d.kind  = kind;
        d.data  = data;
        d.len   = len;
        d.reps  = reps;
        d.typed = typed;
        d.want  = want;
        return d;
    endfunction

    // Apply one accepted request to the shadow ring and queue its results
    task automatic step_ring(input req_t it, input bit typed, input rsp_t typed_rsp);
        logic [FILL_W-1:0] fill;
        rsp_t              computed[$];
        int                n;
        fill = ring_wr - ring_rd;
        case (it.kind)
            KIND_PUSH:
            begin
                if (fill == CAP)
                    computed.push_back(done_rsp(ST_FULL, fill));
                else
                begin
                    ring_mem[ring_wr] = it.push_byte;
                    ring_wr = ring_wr + 1'b1;
                    computed.push_back(done_rsp(ST_OK, fill + 1'b1));
                end
            end
            KIND_GET, KIND_SKIP:
            begin
                if (it.length > fill)
                    computed.push_back(done_rsp((int'(it.length) > CAP) ? ST_NEVER : ST_NOT_YET,
                                                fill));
                else if (it.length == 0)
                    computed.push_back(done_rsp(ST_OK, fill));
                else if (it.kind == KIND_SKIP)
                begin
                    ring_rd = ring_rd + it.length[PTR_W-1:0];
                    computed.push_back(done_rsp(ST_OK, fill - it.length[FILL_W-1:0]));
                end
                else
                begin
                    // Stream the bytes oldest first, fill counting down
                    for (n = 0; n < it.length; n++)
                    begin
                        fill = fill - 1'b1;
                        computed.push_back(make_rsp(ring_mem[ring_rd], 1'b1, ST_OK,
                                                    n == it.length - 1, fill));
                        ring_rd = ring_rd + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (typed)
            due_results.push_back(typed_rsp);
        else
            due_results = {due_results, computed};
    endtask

    // Offer one request, with random idle cycles first; returns at the next falling edge
    task automatic offer(input req_t it, input bit typed, input rsp_t typed_rsp);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (req_ready !== 1'b1)
            @(posedge clk);
        step_ring(it, typed, typed_rsp);
        @(negedge clk);
    endtask

    // Mostly fill-then-drain runs with lengths the ring can serve, plus noise
    task automatic pick_random_request(output req_t it);
        logic [FILL_W-1:0] fill;
        int                roll;
        int                span;
        fill = ring_wr - ring_rd;
        if (fill == 0)
            filling = 1'b1;
        else if (fill == CAP && $urandom_range(99) < 30)
            filling = 1'b0;
        else if ($urandom_range(99) < 4)
            filling = !filling;
        it.push_byte = BYTE_W'($urandom_range(255));
        it.length    = LEN_W'($urandom_range(CAP + 1));
        roll = $urandom_range(99);
        if (roll < 3)
            it.kind = KIND_NONE;
        else if (roll < (filling ? 75 : 25))
            it.kind = KIND_PUSH;
        else
        begin
            it.kind = ($urandom_range(2) == 0) ? KIND_SKIP : KIND_GET;
            roll = $urandom_range(99);
            if (roll < 70 && fill != 0)
            begin
                span = (fill > 8 && $urandom_range(3) != 0) ? 8 : int'(fill);
                it.length = LEN_W'($urandom_range(span, 1));
            end
            else if (roll < 85 && fill != CAP)
                it.length = LEN_W'($urandom_range(CAP, fill + 1));
            else if (roll < 92)
                it.length = '0;
            else
                it.length = LEN_W'(CAP + 1);
        end
    endtask

    // Receiver: random back-pressure, or one long hold-off when asked
    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (stall_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge clk);
                stall_rsp = 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest owed result
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: byte %h valid %b status %0d last %b fill %0d",
                             rsp.out_byte, rsp.byte_valid, rsp.status, rsp.last,
                             rsp.fill_level);
            end
            else
            begin
                want = due_results.pop_front();
                if (rsp !== want)
                begin
                    errors++;
                    // Fields in order: byte, valid, status, last, fill
                    if (errors <= REPORT_MAX)
                        $display("mismatch: want %h/%b/%0d/%b/%0d got %h/%b/%0d/%b/%0d",
                                 want.out_byte, want.byte_valid, want.status, want.last,
                                 want.fill_level, rsp.out_byte, rsp.byte_valid, rsp.status,
                                 rsp.last, rsp.fill_level);
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t rows [22];
        req_t     it;
        int       n;
        int       phase;
        int       sent;
        rows = '{
            row(KIND_GET,  8'h00, 7'd64, 1,  1, done_rsp(ST_NEVER, 6'd0)),
            row(KIND_SKIP, 8'h00, 7'd64, 1,  1, done_rsp(ST_NEVER, 6'd0)),
            row(KIND_GET,  8'hFF, 7'd0,  1,  1, done_rsp(ST_OK, 6'd0)),
            row(KIND_SKIP, 8'h00, 7'd0,  1,  1, done_rsp(ST_OK, 6'd0)),
            row(KIND_GET,  8'h00, 7'd1,  1,  1, done_rsp(ST_NOT_YET, 6'd0)),
            row(KIND_SKIP, 8'h00, 7'd63, 1,  1, done_rsp(ST_NOT_YET, 6'd0)),
            row(KIND_NONE, 8'hFF, 7'd64, 1,  0, '0),
            row(KIND_PUSH, 8'h00, 7'd0,  1,  1, done_rsp(ST_OK, 6'd1)),
            row(KIND_PUSH, 8'hFF, 7'd64, 1,  1, done_rsp(ST_OK, 6'd2)),
            row(KIND_PUSH, 8'h5A, 7'd0,  1,  1, done_rsp(ST_OK, 6'd3)),
            row(KIND_GET,  8'h00, 7'd2,  1,  0, '0),
            row(KIND_GET,  8'h00, 7'd2,  1,  1, done_rsp(ST_NOT_YET, 6'd1)),
            row(KIND_SKIP, 8'h00, 7'd1,  1,  1, done_rsp(ST_OK, 6'd0)),
            row(KIND_PUSH, 8'h80, 7'd0,  63, 0, '0),
            row(KIND_PUSH, 8'hC3, 7'd0,  1,  1, done_rsp(ST_FULL, 6'd63)),
            row(KIND_GET,  8'h00, 7'd64, 1,  1, done_rsp(ST_NEVER, 6'd63)),
            row(KIND_SKIP, 8'h00, 7'd0,  1,  1, done_rsp(ST_OK, 6'd63)),
            row(KIND_GET,  8'h00, 7'd63, 1,  0, '0),
            row(KIND_PUSH, 8'h11, 7'd0,  40, 0, '0),
            row(KIND_SKIP, 8'h00, 7'd30, 1,  1, done_rsp(ST_OK, 6'd10)),
            row(KIND_GET,  8'h00, 7'd10, 1,  0, '0),
            row(KIND_NONE, 8'h00, 7'd0,  1,  0, '0)
        };

        // Hold reset, then release it away from the active edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (rows[r])
        begin
            for (n = 0; n < rows[r].reps; n++)
            begin
                it.kind      = rows[r].kind;
                it.push_byte = rows[r].data + BYTE_W'(n);
                it.length    = rows[r].len;
                offer(it, rows[r].typed, rows[r].want);
            end
        end

        // Random traffic in three idling phases; long receiver hold-off opens the last
        sent = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            @(posedge clk);
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 31 : 0;
            if (phase == 2)
                stall_rsp = 1'b1;
            @(negedge clk);
            while (sent < RANDOM_ITEMS * (phase + 1) / 3)
            begin
                pick_random_request(it);
                offer(it, 1'b0, '0);
                if (it.kind != KIND_NONE)
                    sent++;
            end
        end
        req_valid <= 1'b0;

        // Drain owed results, then watch a little longer for strays
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && due_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
